/* src/dpq_pkg.sv */
// Shared types and constants of the dithered palette quantizer.
`default_nettype none

package dpq_pkg;

  localparam int CHAN_W     = 8;
  localparam int ENTRY_W    = 6;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CODE_W     = 7;
  localparam int ROW_W      = 8;
  localparam int HEIGHT_W   = 9;
  localparam int MAX_HEIGHT = 256;
  localparam int FW_REG_W   = 9;
  localparam int FH_REG_W   = 9;
  localparam int PC_REG_W   = 7;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [CODE_W-1:0] TRANSPARENT_CODE = 7'h7F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_PALETTE_COUNT,
    REG_DITHER_ENABLE
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TGT_RIGHT,
    TGT_DOWN_LEFT,
    TGT_DOWN,
    TGT_DOWN_RIGHT
  } err_tgt_e;

  typedef enum logic [2:0] {
    EOP_NONE,
    EOP_CLEAR,
    EOP_READ_CUR,
    EOP_ZERO_CUR,
    EOP_READ_TGT,
    EOP_WRITE_TGT
  } err_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ERR_READ,
    ST_ADJUST,
    ST_SEARCH,
    ST_ERR_CALC,
    ST_RMW_READ,
    ST_RMW_WRITE,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic     pal_we;
    logic     pix_load;
    logic     adj_load;
    logic     search_start;
    logic     e_load;
    logic     out_load;
    err_op_e  err_op;
    err_tgt_e tgt;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic search_busy;
    logic transparent;
    logic dither;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/dpq_ctrl.sv */
// Controller state machine that sequences the quantizer datapath.
`default_nettype none

module dpq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_is_pixel_i,
  input  logic                geom_wr_i,
  input  dpq_pkg::dp_status_t status_i,
  output dpq_pkg::dp_cmd_t    cmd_o,
  output logic                in_stall_o
);
  import dpq_pkg::*;

  ctrl_state_e state_q, state_d;
  err_tgt_e    tgt_q, tgt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      tgt_q   <= TGT_RIGHT;
    end else begin
      state_q <= state_d;
      tgt_q   <= tgt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    tgt_d   = tgt_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && in_is_pixel_i) state_d = ST_ERR_READ;
      end
      ST_ERR_READ: state_d = ST_ADJUST;
      ST_ADJUST: begin
        state_d = status_i.transparent ? ST_FINISH : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!status_i.search_busy) state_d = status_i.dither ? ST_ERR_CALC : ST_FINISH;
      end
      ST_ERR_CALC: begin
        state_d = ST_RMW_READ;
        tgt_d   = TGT_RIGHT;
      end
      ST_RMW_READ: state_d = ST_RMW_WRITE;
      ST_RMW_WRITE: begin
        case (tgt_q)
          TGT_RIGHT: begin
            tgt_d   = TGT_DOWN_LEFT;
            state_d = ST_RMW_READ;
          end
          TGT_DOWN_LEFT: begin
            tgt_d   = TGT_DOWN;
            state_d = ST_RMW_READ;
          end
          TGT_DOWN: begin
            tgt_d   = TGT_DOWN_RIGHT;
            state_d = ST_RMW_READ;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (geom_wr_i) state_d = ST_CLEAR;
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.err_op = EOP_NONE;
    cmd_o.tgt    = tgt_q;
    case (state_q)
      ST_CLEAR: cmd_o.err_op = EOP_CLEAR;
      ST_IDLE: begin
        cmd_o.pal_we   = in_valid_i && !in_is_pixel_i;
        cmd_o.pix_load = in_valid_i && in_is_pixel_i;
      end
      ST_ERR_READ: cmd_o.err_op = EOP_READ_CUR;
      ST_ADJUST: begin
        cmd_o.adj_load     = 1'b1;
        cmd_o.err_op       = EOP_ZERO_CUR;
        cmd_o.search_start = !status_i.transparent;
      end
      ST_ERR_CALC: cmd_o.e_load = 1'b1;
      ST_RMW_READ: cmd_o.err_op = EOP_READ_TGT;
      ST_RMW_WRITE: cmd_o.err_op = EOP_WRITE_TGT;
      ST_FINISH: cmd_o.out_load = status_i.out_free;
      default: cmd_o.err_op = EOP_NONE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

/* src/dpq_datapath.sv */
// Datapath with palette memory, error row memory, distance search and output register.
`default_nettype none

module dpq_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_COLORS = 64,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dpq_pkg::dp_cmd_t                       cmd_i,
  output dpq_pkg::dp_status_t                    status_o,
  input  logic [dpq_pkg::ENTRY_W-1:0]            entry_index_i,
  input  logic [dpq_pkg::CHAN_W-1:0]             red_i,
  input  logic [dpq_pkg::CHAN_W-1:0]             green_i,
  input  logic [dpq_pkg::CHAN_W-1:0]             blue_i,
  input  logic [dpq_pkg::CHAN_W-1:0]             alpha_i,
  input  logic [$clog2(MAX_WIDTH):0]             eff_width_i,
  input  logic [dpq_pkg::HEIGHT_W-1:0]           eff_height_i,
  input  logic [$clog2(MAX_COLORS+1)-1:0]        eff_colors_i,
  input  logic                                   dither_i,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic signed [dpq_pkg::CODE_W-1:0]      color_index_o,
  output logic                                   frame_last_o
);
  import dpq_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WW    = XW + 1;
  localparam int AW    = XW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int CW    = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int PDEP  = 2 ** CW;
  localparam int NW    = $clog2(MAX_COLORS + 1);
  localparam int AJW   = FRAC_BITS + 8;
  localparam int DFW   = FRAC_BITS + 9;
  localparam int SQW   = 2 * FRAC_BITS + 16;
  localparam int DW    = SQW + 2;
  localparam int EW    = FRAC_BITS + 11;

  localparam logic [AJW-1:0] CHAN_MAX = {8'hFF, {FRAC_BITS{1'b0}}};
  localparam logic signed [EW:0] ERR_MAX = (EW+1)'((1 << (FRAC_BITS + 10)) - 1);
  localparam logic signed [EW:0] ERR_MIN = -ERR_MAX;
  localparam logic [2:0] W_RIGHT      = 3'd7;
  localparam logic [2:0] W_DOWN_LEFT  = 3'd3;
  localparam logic [2:0] W_DOWN       = 3'd5;
  localparam logic [2:0] W_DOWN_RIGHT = 3'd1;

  function automatic logic [AJW-1:0] adjust(logic [7:0] ch, logic [EW-1:0] err,
                                            logic use_err);
    logic signed [EW:0] sum;
    sum = $signed({{(EW+1-AJW){1'b0}}, ch, {FRAC_BITS{1'b0}}});
    if (use_err) sum = sum + $signed({err[EW-1], err});
    if (sum < 0) return '0;
    else if (sum > $signed({{(EW+1-AJW){1'b0}}, CHAN_MAX})) return CHAN_MAX;
    else return sum[AJW-1:0];
  endfunction

  function automatic logic [EW-1:0] share(logic [DFW-1:0] e, logic [2:0] w);
    logic [DFW-1:0] mag;
    logic [DFW+2:0] prod;
    logic [EW-1:0]  t;
    mag  = e[DFW-1] ? (~e + 1'b1) : e;
    prod = (DFW+3)'(mag) * (DFW+3)'(w) + (DFW+3)'(8);
    t    = EW'(prod[DFW+2:4]);
    return e[DFW-1] ? (~t + 1'b1) : t;
  endfunction

  function automatic logic [EW-1:0] accum(logic [EW-1:0] acc, logic [EW-1:0] sh);
    logic signed [EW:0] sum;
    sum = $signed({acc[EW-1], acc}) + $signed({sh[EW-1], sh});
    if (sum > ERR_MAX) return ERR_MAX[EW-1:0];
    else if (sum < ERR_MIN) return ERR_MIN[EW-1:0];
    else return sum[EW-1:0];
  endfunction

  function automatic logic [2:0] weight(err_tgt_e t);
    case (t)
      TGT_RIGHT:     return W_RIGHT;
      TGT_DOWN_LEFT: return W_DOWN_LEFT;
      TGT_DOWN:      return W_DOWN;
      default:       return W_DOWN_RIGHT;
    endcase
  endfunction

  logic [2:0][7:0]       pix_q;
  logic                  transp_q;
  logic [2:0][AJW-1:0]   adj_q;
  logic [2:0][DFW-1:0]   e_q;
  logic [2:0][DFW-1:0]   e_d;
  logic [3*EW-1:0]       err_mem [DEPTH];
  logic [3*EW-1:0]       err_rd_q;
  logic [3*EW-1:0]       err_wr;
  logic [2:0][7:0]       pal_mem [PDEP];
  logic [2:0][7:0]       pal_rd_q;
  logic [XW-1:0]         x_q;
  logic [ROW_W-1:0]      y_q;
  logic                  bank_q;
  logic [AW-1:0]         clr_q;
  logic                  row_end;
  logic                  last_row;
  logic [AW-1:0]         cur_addr;
  logic [AW-1:0]         tgt_addr;
  logic                  tgt_ok;
  logic [XW-1:0]         x_inc;
  logic [XW-1:0]         x_dec;
  logic                  issuing_q;
  logic [NW-1:0]         rd_idx_q;
  logic                  v1_q;
  logic [CW-1:0]         idx1_q;
  logic                  v2_q;
  logic [CW-1:0]         idx2_q;
  logic [2:0][7:0]       rgb2_q;
  logic [2:0][DFW-1:0]   diff;
  logic [2:0][2*DFW-1:0] prod;
  logic [2:0][SQW-1:0]   sq_q;
  logic [DW-1:0]         dist_sum;
  logic [DW-1:0]         best_d_q;
  logic [CW-1:0]         best_idx_q;
  logic [2:0][7:0]       best_rgb_q;
  logic                  out_valid_q;
  logic [CODE_W-1:0]     out_idx_q;
  logic                  out_last_q;
  logic                  out_free;
  logic                  slot_ok;

  assign row_end  = (({1'b0, x_q} + WW'(1)) >= eff_width_i);
  assign last_row = (({1'b0, y_q} + HEIGHT_W'(1)) >= eff_height_i);
  assign x_inc    = x_q + XW'(1);
  assign x_dec    = x_q - XW'(1);
  assign cur_addr = {bank_q, x_q};

  always_comb begin
    case (cmd_i.tgt)
      TGT_RIGHT: begin
        tgt_addr = {bank_q, x_inc};
        tgt_ok   = !row_end;
      end
      TGT_DOWN_LEFT: begin
        tgt_addr = {~bank_q, x_dec};
        tgt_ok   = !last_row && (x_q != '0);
      end
      TGT_DOWN: begin
        tgt_addr = {~bank_q, x_q};
        tgt_ok   = !last_row;
      end
      default: begin
        tgt_addr = {~bank_q, x_inc};
        tgt_ok   = !row_end && !last_row;
      end
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      err_wr[c*EW +: EW] = accum(err_rd_q[c*EW +: EW], share(e_q[c], weight(cmd_i.tgt)));
      diff[c] = {1'b0, adj_q[c]} - {1'b0, pal_rd_q[c], {FRAC_BITS{1'b0}}};
      prod[c] = $signed(diff[c]) * $signed(diff[c]);
      e_d[c]  = {1'b0, adj_q[c]} - {1'b0, best_rgb_q[c], {FRAC_BITS{1'b0}}};
    end
    dist_sum = DW'(sq_q[0]) + DW'(sq_q[1]) + DW'(sq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.err_op)
      EOP_CLEAR:     err_mem[clr_q] <= '0;
      EOP_READ_CUR:  err_rd_q <= err_mem[cur_addr];
      EOP_ZERO_CUR:  err_mem[cur_addr] <= '0;
      EOP_READ_TGT:  err_rd_q <= err_mem[tgt_addr];
      EOP_WRITE_TGT: begin
        if (tgt_ok) err_mem[tgt_addr] <= err_wr;
      end
      default: ;
    endcase
  end

  assign slot_ok = (32'(entry_index_i) < MAX_COLORS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pal_we && slot_ok) pal_mem[CW'(entry_index_i)] <= {blue_i, green_i, red_i};
    pal_rd_q <= pal_mem[rd_idx_q[CW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      pix_q    <= {blue_i, green_i, red_i};
      transp_q <= (alpha_i == '0);
    end
    if (cmd_i.adj_load) begin
      for (int c = 0; c < 3; c++) adj_q[c] <= adjust(pix_q[c], err_rd_q[c*EW +: EW], dither_i);
    end
    if (cmd_i.e_load) e_q <= e_d;
    idx1_q <= rd_idx_q[CW-1:0];
    idx2_q <= idx1_q;
    rgb2_q <= pal_rd_q;
    for (int c = 0; c < 3; c++) sq_q[c] <= prod[c][SQW-1:0];
    if (v2_q && ((idx2_q == '0) || (dist_sum < best_d_q))) begin
      best_d_q   <= dist_sum;
      best_idx_q <= idx2_q;
      best_rgb_q <= rgb2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b0;
      rd_idx_q  <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
    end else begin
      v1_q <= issuing_q;
      v2_q <= v1_q;
      if (cmd_i.search_start) begin
        issuing_q <= 1'b1;
        rd_idx_q  <= '0;
      end else if (issuing_q) begin
        rd_idx_q <= rd_idx_q + NW'(1);
        if ((rd_idx_q + NW'(1)) == eff_colors_i) issuing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      bank_q <= 1'b0;
    end else begin
      if (cmd_i.err_op == EOP_CLEAR) begin
        clr_q <= clr_q + AW'(1);
        x_q   <= '0;
        y_q   <= '0;
      end else if (cmd_i.out_load) begin
        if (row_end && last_row) begin
          x_q <= '0;
          y_q <= '0;
        end else if (row_end) begin
          x_q    <= '0;
          y_q    <= y_q + ROW_W'(1);
          bank_q <= ~bank_q;
        end else begin
          x_q <= x_inc;
        end
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q  <= transp_q ? TRANSPARENT_CODE : CODE_W'(best_idx_q);
      out_last_q <= row_end && last_row;
    end
  end

  assign status_o.clear_done  = (clr_q == '1);
  assign status_o.search_busy = issuing_q || v1_q || v2_q;
  assign status_o.transparent = transp_q;
  assign status_o.dither      = dither_i;
  assign status_o.out_free    = out_free;

  assign out_valid_o   = out_valid_q;
  assign color_index_o = $signed(out_idx_q);
  assign frame_last_o  = out_last_q;

endmodule

`default_nettype wire

/* src/dithered_palette_quantizer.sv */
// Top level of the dithered palette quantizer with configuration registers.
//
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_stall_o   cmd, entry_index, red, green, blue, alpha
// out      output     out_valid_o/out_stall_i color_index, frame_last
// cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// A pixel reads its error entry, adjusts its colour and searches the palette, the distance
// unit stepping one palette entry a cycle; with dithering it then spreads the error to four
// neighbours. A transparent pixel skips the search and the error spreading.
// After reset and after each frame_width or frame_height write, a clearing pass zeroes all
// 2 * 2**clog2(MAX_WIDTH) error-row entries while in_stall_o is high.
// A result waits in the output register while the next beat is already being worked on.
`default_nettype none

module dithered_palette_quantizer #(
  parameter int MAX_WIDTH           = 256,
  parameter int MAX_COLORS          = 64,
  parameter int ERROR_FRACTION_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [dpq_pkg::ENTRY_W-1:0]        entry_index_i,
  input  logic [dpq_pkg::CHAN_W-1:0]         red_i,
  input  logic [dpq_pkg::CHAN_W-1:0]         green_i,
  input  logic [dpq_pkg::CHAN_W-1:0]         blue_i,
  input  logic [dpq_pkg::CHAN_W-1:0]         alpha_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [dpq_pkg::CODE_W-1:0]  color_index_o,
  output logic                               frame_last_o,
  input  logic                               cfg_we_i,
  input  logic [dpq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dpq_pkg::CFG_W-1:0]          cfg_data_i
);
  import dpq_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH) + 1;
  localparam int NW = $clog2(MAX_COLORS + 1);

  logic [FW_REG_W-1:0] fw_q;
  logic [FH_REG_W-1:0] fh_q;
  logic [PC_REG_W-1:0] pc_q;
  logic                de_q;
  logic [WW-1:0]       eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [NW-1:0]       eff_n;
  logic                geom_wr;
  dp_cmd_t             cmd;
  dp_status_t          status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_REG_W'(1);
      fh_q <= FH_REG_W'(1);
      pc_q <= PC_REG_W'(1);
      de_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:   fw_q <= cfg_data_i[FW_REG_W-1:0];
        REG_FRAME_HEIGHT:  fh_q <= cfg_data_i[FH_REG_W-1:0];
        REG_PALETTE_COUNT: pc_q <= cfg_data_i[PC_REG_W-1:0];
        REG_DITHER_ENABLE: de_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q == '0) eff_w = WW'(1);
    else if (32'(fw_q) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(fw_q);
    if (fh_q == '0) eff_h = HEIGHT_W'(1);
    else if (32'(fh_q) > MAX_HEIGHT) eff_h = HEIGHT_W'(MAX_HEIGHT);
    else eff_h = fh_q;
    if (pc_q == '0) eff_n = NW'(1);
    else if (32'(pc_q) > MAX_COLORS) eff_n = NW'(MAX_COLORS);
    else eff_n = NW'(pc_q);
  end

  assign geom_wr = cfg_we_i && ((cfg_index_i == REG_FRAME_WIDTH) ||
                                (cfg_index_i == REG_FRAME_HEIGHT));

  dpq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_is_pixel_i (cmd_i == CMD_PIXEL),
    .geom_wr_i     (geom_wr),
    .status_i      (status),
    .cmd_o         (cmd),
    .in_stall_o    (in_stall_o)
  );

  dpq_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_COLORS (MAX_COLORS),
    .FRAC_BITS  (ERROR_FRACTION_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .alpha_i       (alpha_i),
    .eff_width_i   (eff_w),
    .eff_height_i  (eff_h),
    .eff_colors_i  (eff_n),
    .dither_i      (de_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .color_index_o (color_index_o),
    .frame_last_o  (frame_last_o)
  );

`ifndef ASSERT_OFF
  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (cmd_i == CMD_PIXEL)) |=> in_stall_o)
    else $error("Accepted pixel beat did not make the block busy.");

  a_geom_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    geom_wr |=> in_stall_o)
    else $error("Geometry write did not start the clearing pass.");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((color_index_o == TRANSPARENT_CODE) ||
                     ({25'b0, color_index_o} < 32'(MAX_COLORS))))
    else $error("Result index outside the palette.");
`endif

endmodule

`default_nettype wire
